// ===== rtl/core/lcd_line_capture_controller_defines.svh =====
// ----------------------------------------------------------------------------
// LCD line capture controller assertion macros
// Shared property wrappers for the checker, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef LCD_LINE_CAPTURE_CONTROLLER_DEFINES_SVH
`define LCD_LINE_CAPTURE_CONTROLLER_DEFINES_SVH

// Property checked only while out of reset.
`define LCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every edge, reset included.
`define LCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller package
// Shared constants, request structs and the grey level table.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int STORE_ADDR_BITS = 18;
  localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
  localparam int MAX_LINE        = 4096;

  localparam logic [12:0] MAX_LINE_V     = 13'(MAX_LINE);
  localparam logic [10:0] HSTART_MAX     = 11'd2047;
  localparam logic [11:0] VSTART_TOP     = 12'd512;
  localparam logic [1:0]  MODE_HALF      = 2'b01;
  localparam logic [13:0] LINE_COUNT_MAX = '1;

  localparam logic [4:0] SEL_CTRL_L = 5'd12;
  localparam logic [4:0] SEL_CTRL_M = 5'd13;
  localparam logic [4:0] SEL_CTRL_H = 5'd14;
  localparam logic [4:0] SEL_RESET  = 5'd15;

  localparam logic [7:0] RD_RESET_REG = 8'd4;
  localparam logic [7:0] RD_UNMAPPED  = 8'hff;

  typedef enum logic [2:0] {
    OP_REG_WR   = 3'd0,
    OP_REG_RD   = 3'd1,
    OP_VSYNC    = 3'd2,
    OP_PIXEL    = 3'd3,
    OP_EOL      = 3'd4,
    OP_FRAME_RD = 3'd5
  } op_e;

  typedef struct packed {
    logic                       en;
    logic [STORE_ADDR_BITS-1:0] addr;
    logic [7:0]                 data;
  } store_wr_t;

  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [3:0] data;
  } pal_wr_t;

  function automatic logic [7:0] grey_level(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:    g = 8'h00;
      4'd1:    g = 8'h1c;
      4'd2:    g = 8'h33;
      4'd3:    g = 8'h44;
      4'd4:    g = 8'h55;
      4'd5:    g = 8'h66;
      4'd6:    g = 8'h71;
      4'd7:    g = 8'h80;
      4'd8:    g = 8'hff;
      4'd9:    g = 8'he3;
      4'd10:   g = 8'hcc;
      4'd11:   g = 8'hbb;
      4'd12:   g = 8'haa;
      4'd13:   g = 8'h99;
      4'd14:   g = 8'h8e;
      default: g = 8'h80;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/lcc_store.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller frame store
// Byte-wide synchronous frame memory with a fill mark standing in for reset.
// ----------------------------------------------------------------------------
module lcc_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lcc_pkg::store_wr_t                 wr_i,
  input  logic                               rd_en_i,
  input  logic [lcc_pkg::STORE_ADDR_BITS-1:0] rd_addr_i,
  output logic [7:0]                         rd_data_o
);
  import lcc_pkg::*;

  // Writes always run upwards from address zero, so everything at or above
  // the fill mark has never been written and reads as zero.
  logic [7:0]               mem [STORE_DEPTH];
  logic [7:0]               rdata_q;
  logic                     hit_q;
  logic [STORE_ADDR_BITS:0] fill_q;
  logic [STORE_ADDR_BITS:0] fill_d;
  logic [STORE_ADDR_BITS:0] wr_next;

  assign wr_next = {1'b0, wr_i.addr} + 1'b1;

  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && (wr_next > fill_q)) begin
      fill_d = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      hit_q   <= ({1'b0, rd_addr_i} < fill_q);
    end
  end

  assign rd_data_o = hit_q ? rdata_q : '0;

endmodule

// ===== rtl/core/lcc_palette.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller palette
// Sixteen grey index entries, held twice so both nibbles look up together.
// ----------------------------------------------------------------------------
module lcc_palette (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcc_pkg::pal_wr_t wr_i,
  input  logic             rd_en_i,
  input  logic [7:0]       byte_i,
  output logic [7:0]       grey_even_o,
  output logic [7:0]       grey_odd_o
);
  import lcc_pkg::*;

  logic [3:0]  mem_even [16];
  logic [3:0]  mem_odd  [16];
  logic [15:0] vld_q;
  logic [15:0] vld_d;
  logic [3:0]  even_q;
  logic [3:0]  odd_q;
  logic        even_vld_q;
  logic        odd_vld_q;

  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_even[wr_i.idx] <= wr_i.data;
      mem_odd[wr_i.idx]  <= wr_i.data;
    end
    if (rd_en_i) begin
      even_q     <= mem_even[byte_i[3:0]];
      odd_q      <= mem_odd[byte_i[7:4]];
      even_vld_q <= vld_q[byte_i[3:0]];
      odd_vld_q  <= vld_q[byte_i[7:4]];
    end
  end

  assign grey_even_o = grey_level(even_vld_q ? even_q : 4'h0);
  assign grey_odd_o  = grey_level(odd_vld_q ? odd_q : 4'h0);

endmodule

// ===== rtl/core/lcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller sequencer
// Timing registers, vertical tracking and the capture window for each request.
// ----------------------------------------------------------------------------
module lcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          opcode_i,
  input  logic [6:0]          reg_addr_i,
  input  logic [7:0]          write_data_i,
  input  logic [11:0]         pixel_pos_i,
  input  logic [3:0]          pixel_value_i,
  input  logic [12:0]         line_pixels_i,
  output lcc_pkg::store_wr_t  store_wr_o,
  output lcc_pkg::pal_wr_t    pal_wr_o,
  output logic [7:0]          read_data_o,
  output logic                frame_ready_o
);
  import lcc_pkg::*;

  typedef enum logic [2:0] {
    REG_VSTART,
    REG_VLINES,
    REG_HSTART,
    REG_HLEN,
    REG_CTRL
  } reg_e;

  typedef struct packed {
    reg_e       id;
    logic [1:0] nib;
  } reg_sel_t;

  function automatic reg_sel_t reg_decode(input logic [3:0] a);
    reg_sel_t r;
    unique case (a)
      4'd0:    r = '{id: REG_VSTART, nib: 2'd0};
      4'd1:    r = '{id: REG_VSTART, nib: 2'd1};
      4'd2:    r = '{id: REG_VSTART, nib: 2'd2};
      4'd3:    r = '{id: REG_VLINES, nib: 2'd0};
      4'd4:    r = '{id: REG_VLINES, nib: 2'd1};
      4'd5:    r = '{id: REG_VLINES, nib: 2'd2};
      4'd6:    r = '{id: REG_HSTART, nib: 2'd0};
      4'd7:    r = '{id: REG_HSTART, nib: 2'd1};
      4'd8:    r = '{id: REG_HSTART, nib: 2'd2};
      4'd9:    r = '{id: REG_HLEN,   nib: 2'd0};
      4'd10:   r = '{id: REG_HLEN,   nib: 2'd1};
      4'd11:   r = '{id: REG_HLEN,   nib: 2'd2};
      4'd12:   r = '{id: REG_CTRL,   nib: 2'd0};
      4'd13:   r = '{id: REG_CTRL,   nib: 2'd1};
      default: r = '{id: REG_CTRL,   nib: 2'd2};
    endcase
    return r;
  endfunction

  function automatic logic [11:0] set_nib(input logic [11:0] r, input logic [1:0] n,
                                          input logic [3:0] v);
    logic [11:0] o;
    o = r;
    case (n)
      2'd0:    o[3:0]  = v;
      2'd1:    o[7:4]  = v;
      default: o[11:8] = v;
    endcase
    return o;
  endfunction

  logic [11:0] vstart_q, vstart_d, vlines_q, vlines_d, hstart_q, hstart_d;
  logic [11:0] hlen_q, hlen_d, ctl_q, ctl_d;
  logic [9:0]  lts_q, lts_d;
  logic        skip_q, skip_d;
  logic [12:0] panel_q, panel_d;
  logic [13:0] lc_q, lc_d;
  logic [3:0]  held_q, held_d;
  logic        held_vld_q, held_vld_d;
  logic [STORE_ADDR_BITS-1:0] wp_q, wp_d;

  logic        half;
  logic [10:0] hs, off_full, off;
  logic [14:0] lim;
  logic [12:0] npix, cnt_min, cnt, pos13, off13, rel;
  logic        in_win;
  logic [13:0] pl2;
  logic        active;
  reg_sel_t    dec;

  assign half     = (ctl_q[6:5] == MODE_HALF);
  assign hs       = (hstart_q > {1'b0, HSTART_MAX}) ? HSTART_MAX : hstart_q[10:0];
  assign off_full = HSTART_MAX - hs;
  assign off      = half ? {1'b0, off_full[10:1]} : off_full;
  assign lim      = half ? {1'b0, hlen_q, 2'b00} : {hlen_q, 3'b000};
  assign npix     = (line_pixels_i > MAX_LINE_V) ? MAX_LINE_V : line_pixels_i;
  assign cnt_min  = ({2'b00, npix} < lim) ? npix : lim[12:0];
  assign cnt      = (cnt_min + 13'd1) & ~13'd1;
  assign pos13    = {1'b0, pixel_pos_i};
  assign off13    = {2'b00, off};
  assign rel      = pos13 - off13;
  assign in_win   = (pos13 < MAX_LINE_V) && (pos13 >= off13) && (rel < cnt);
  assign pl2      = {panel_q, 1'b0};
  assign active   = !skip_q && (lts_q == '0) && (lc_q < pl2);
  assign dec      = reg_decode(reg_addr_i[5:2]);

  always_comb begin
    vstart_d      = vstart_q;
    vlines_d      = vlines_q;
    hstart_d      = hstart_q;
    hlen_d        = hlen_q;
    ctl_d         = ctl_q;
    lts_d         = lts_q;
    skip_d        = skip_q;
    panel_d       = panel_q;
    lc_d          = lc_q;
    held_d        = held_q;
    held_vld_d    = held_vld_q;
    wp_d          = wp_q;
    store_wr_o    = '0;
    pal_wr_o      = '0;
    read_data_o   = '0;
    frame_ready_o = 1'b0;
    if (accept_i) begin
      unique case (op_e'(opcode_i))
        OP_REG_WR: begin
          if (!reg_addr_i[6] && (reg_addr_i[5:2] != 4'hf)) begin
            unique case (dec.id)
              REG_VSTART: vstart_d = set_nib(vstart_q, dec.nib, write_data_i[3:0]);
              REG_VLINES: vlines_d = set_nib(vlines_q, dec.nib, write_data_i[3:0]);
              REG_HSTART: hstart_d = set_nib(hstart_q, dec.nib, write_data_i[3:0]);
              REG_HLEN:   hlen_d   = set_nib(hlen_q, dec.nib, write_data_i[3:0]);
              default:    ctl_d    = set_nib(ctl_q, dec.nib, write_data_i[3:0]);
            endcase
          end
          if (reg_addr_i[6]) begin
            pal_wr_o.en   = 1'b1;
            pal_wr_o.idx  = reg_addr_i[5:2];
            pal_wr_o.data = write_data_i[3:0];
          end
        end
        OP_REG_RD: begin
          unique case (reg_addr_i[6:2])
            SEL_CTRL_L: read_data_o = {4'h0, ctl_q[3:0]};
            SEL_CTRL_M: read_data_o = {4'h0, ctl_q[7:4]};
            SEL_CTRL_H: read_data_o = {4'h0, ctl_q[11:8]};
            SEL_RESET:  read_data_o = RD_RESET_REG;
            default:    read_data_o = RD_UNMAPPED;
          endcase
        end
        OP_VSYNC: begin
          wp_d       = '0;
          lc_d       = '0;
          held_vld_d = 1'b0;
          held_d     = '0;
          panel_d    = {1'b0, vlines_q} + 13'd3;
          if (vstart_q > VSTART_TOP) begin
            skip_d = 1'b1;
            lts_d  = '0;
          end else begin
            skip_d = 1'b0;
            lts_d  = 10'(VSTART_TOP - vstart_q);
          end
        end
        OP_PIXEL: begin
          if (active && in_win) begin
            if (half) begin
              store_wr_o.en   = 1'b1;
              store_wr_o.addr = wp_q;
              store_wr_o.data = {pixel_value_i, pixel_value_i};
              wp_d            = wp_q + 1'b1;
            end else if (!rel[0]) begin
              held_d     = pixel_value_i;
              held_vld_d = 1'b1;
            end else begin
              store_wr_o.en   = 1'b1;
              store_wr_o.addr = wp_q;
              store_wr_o.data = {pixel_value_i, held_vld_q ? held_q : 4'h0};
              wp_d            = wp_q + 1'b1;
              held_vld_d      = 1'b0;
            end
          end
        end
        OP_EOL: begin
          if (!skip_q) begin
            if (lts_q != '0) begin
              lts_d      = lts_q - 1'b1;
              held_vld_d = 1'b0;
            end else begin
              if (held_vld_q && active) begin
                store_wr_o.en   = 1'b1;
                store_wr_o.addr = wp_q;
                store_wr_o.data = {4'h0, held_q};
                wp_d            = wp_q + 1'b1;
              end
              held_vld_d = 1'b0;
              held_d     = '0;
              if (lc_q != LINE_COUNT_MAX) begin
                lc_d = lc_q + 1'b1;
              end
              frame_ready_o = (lc_d == {1'b0, panel_q}) || (lc_d == pl2);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstart_q   <= '0;
      vlines_q   <= '0;
      hstart_q   <= '0;
      hlen_q     <= '0;
      ctl_q      <= '0;
      lts_q      <= '0;
      skip_q     <= 1'b0;
      panel_q    <= '0;
      lc_q       <= '0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      wp_q       <= '0;
    end else begin
      vstart_q   <= vstart_d;
      vlines_q   <= vlines_d;
      hstart_q   <= hstart_d;
      hlen_q     <= hlen_d;
      ctl_q      <= ctl_d;
      lts_q      <= lts_d;
      skip_q     <= skip_d;
      panel_q    <= panel_d;
      lc_q       <= lc_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      wp_q       <= wp_d;
    end
  end

endmodule

// ===== rtl/core/lcd_line_capture_controller.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller
// Captures a window of each video line into a packed frame store and returns
// palette grey levels for frame byte reads.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  input    in_valid_i / in_ready_o   opcode, reg_addr, write_data, pixel_pos,
//                                     pixel_value, line_pixels, frame_addr
//  output   out_valid_o / out_ready_i read_data, grey_even, grey_odd,
//                                     frame_ready
//
// One request is taken every cycle unless a stalled output backs up the pipe;
// each result passes the frame store read, palette read and output registers.
// Reset takes effect at once; the frame store needs no clearing pass, as a
// fill mark makes unwritten bytes read as zero.
// A stalled output holds the pipeline stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module lcd_line_capture_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [11:0] pixel_pos_i,
  input  logic [3:0]  pixel_value_i,
  input  logic [12:0] line_pixels_i,
  input  logic [17:0] frame_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [7:0]  grey_even_o,
  output logic [7:0]  grey_odd_o,
  output logic        frame_ready_o
);
  import lcc_pkg::*;

  logic       accept;
  logic       is_frd;
  store_wr_t  store_wr;
  pal_wr_t    pal_wr;
  logic [7:0] c_rd;
  logic       c_fr;
  logic [7:0] store_byte;
  logic [7:0] grey_even;
  logic [7:0] grey_odd;

  logic       s1_valid_q, s1_frd_q, s1_fr_q;
  logic [7:0] s1_rd_q;
  logic       s2_valid_q, s2_frd_q, s2_fr_q;
  logic [7:0] s2_rd_q;
  logic       out_valid_q, out_fr_q;
  logic [7:0] out_rd_q, out_ge_q, out_go_q;

  logic out_free, s2_free, s2_adv, s1_free, s1_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_frd     = (op_e'(opcode_i) == OP_FRAME_RD);

  lcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .opcode_i      (opcode_i),
    .reg_addr_i    (reg_addr_i),
    .write_data_i  (write_data_i),
    .pixel_pos_i   (pixel_pos_i),
    .pixel_value_i (pixel_value_i),
    .line_pixels_i (line_pixels_i),
    .store_wr_o    (store_wr),
    .pal_wr_o      (pal_wr),
    .read_data_o   (c_rd),
    .frame_ready_o (c_fr)
  );

  lcc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (store_wr),
    .rd_en_i   (accept && is_frd),
    .rd_addr_i (frame_addr_i[STORE_ADDR_BITS-1:0]),
    .rd_data_o (store_byte)
  );

  lcc_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (pal_wr),
    .rd_en_i     (s1_adv && s1_frd_q),
    .byte_i      (store_byte),
    .grey_even_o (grey_even),
    .grey_odd_o  (grey_odd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= accept;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_frd_q <= is_frd;
      s1_fr_q  <= c_fr;
      s1_rd_q  <= c_rd;
    end
    if (s1_adv) begin
      s2_frd_q <= s1_frd_q;
      s2_fr_q  <= s1_fr_q;
      s2_rd_q  <= s1_rd_q;
    end
    if (s2_adv) begin
      out_fr_q <= s2_fr_q;
      out_rd_q <= s2_rd_q;
      out_ge_q <= s2_frd_q ? grey_even : 8'h00;
      out_go_q <= s2_frd_q ? grey_odd : 8'h00;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rd_q;
  assign grey_even_o   = out_ge_q;
  assign grey_odd_o    = out_go_q;
  assign frame_ready_o = out_fr_q;

endmodule

// ===== rtl/core/lcc_checker.sv =====
// ----------------------------------------------------------------------------
// LCD line capture controller checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_line_capture_controller_defines.svh"

module lcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic [7:0]  grey_even_o,
  input logic [7:0]  grey_odd_o,
  input logic        frame_ready_o
);

  `LCC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

  `LCC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(grey_even_o) && $stable(frame_ready_o), "stalled result changed")

  `LCC_ASSERT(a_frame_ready_alone, out_valid_o && frame_ready_o |-> read_data_o == 8'h00 && grey_even_o == 8'h00 && grey_odd_o == 8'h00, "frame ready mixed with other fields")

  `LCC_ASSERT(a_read_data_alone, out_valid_o && read_data_o != 8'h00 |-> !frame_ready_o && grey_even_o == 8'h00 && grey_odd_o == 8'h00, "register read mixed with other fields")

endmodule

bind lcd_line_capture_controller lcc_checker u_checker (.*);

// ===== sim/lcc_capture_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD line capture controller checker
// Watches both channels of the controller and keeps its own copy of the
// timing registers, the palette, the line counters and the whole frame store.
// The expected result of each accepted request is queued. Each accepted
// result is then compared field by field with the oldest entry in the queue.
// ----------------------------------------------------------------------------
module lcc_capture_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [11:0] pixel_pos_i,
  input  logic [3:0]  pixel_value_i,
  input  logic [12:0] line_pixels_i,
  input  logic [17:0] frame_addr_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  read_data_i,
  input  logic [7:0]  grey_even_i,
  input  logic [7:0]  grey_odd_i,
  input  logic        frame_ready_i,
  output int          fail_count_o,
  output int          results_due_o
);
  import lcc_pkg::*;

  localparam int GRP_VSTART  = 0;
  localparam int GRP_VLINES  = 1;
  localparam int GRP_HSTART  = 2;
  localparam int GRP_HLEN    = 3;
  localparam int GRP_CTRL    = 4;
  localparam int MAX_REPORTS = 40;

  // Grey level per palette index, entry 0 in the lowest byte.
  localparam logic [127:0] GREY_LEVELS = 128'h808e99aabbcce3ff_8071665544331c00;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] grey_even;
    logic [7:0] grey_odd;
    logic       frame_ready;
  } lcd_result_t;

  lcd_result_t awaited_results [$];

  bit   [7:0]  frame_image [STORE_DEPTH];
  bit   [3:0]  grey_idx [16];
  logic [17:0] fill_ptr   = '0;
  logic [11:0] vstart_r   = '0;
  logic [11:0] vlines_r   = '0;
  logic [11:0] hstart_r   = '0;
  logic [11:0] hlen_r     = '0;
  logic [11:0] ctrl_r     = '0;
  logic [3:0]  held_pix   = '0;
  bit          held_ok    = 1'b0;
  bit          skip_frame = 1'b0;
  int unsigned skip_left  = 0;
  int unsigned panel_len  = 0;
  int unsigned lines_seen = 0;
  int          failures   = 0;
  int          due_count  = 0;

  assign fail_count_o  = failures;
  assign results_due_o = due_count;

  function automatic void log_failure(string msg);
    if (failures < MAX_REPORTS) begin
      $display("%s", msg);
    end
    failures++;
  endfunction

  function automatic bit line_live();
    return !skip_frame && skip_left == 0 && lines_seen < 2 * panel_len;
  endfunction

  function automatic void append_byte(logic [7:0] value);
    frame_image[fill_ptr] = value;
    fill_ptr = fill_ptr + 1'b1;
  endfunction

  function automatic lcd_result_t capture_outcome(
      input logic [2:0]  opcode,
      input logic [6:0]  addr,
      input logic [7:0]  data,
      input logic [11:0] pos,
      input logic [3:0]  pix,
      input logic [12:0] npix,
      input logic [17:0] faddr);
    lcd_result_t res;
    logic [4:0]  sel;
    logic [7:0]  stored;
    int unsigned grp, nib, off, lim, cnt, rel;
    bit          half;
    res = '0;
    sel = addr[6:2];
    case (opcode)
      OP_REG_WR: begin
        if (sel < SEL_RESET) begin
          grp = sel / 3;
          nib = sel % 3;
          case (grp)
            GRP_VSTART: vstart_r[4*nib +: 4] = data[3:0];
            GRP_VLINES: vlines_r[4*nib +: 4] = data[3:0];
            GRP_HSTART: hstart_r[4*nib +: 4] = data[3:0];
            GRP_HLEN:   hlen_r[4*nib +: 4]   = data[3:0];
            GRP_CTRL:   ctrl_r[4*nib +: 4]   = data[3:0];
            default: ;
          endcase
        end
        if (addr[6]) begin
          grey_idx[addr[5:2]] = data[3:0];
        end
      end
      OP_REG_RD: begin
        case (sel)
          SEL_CTRL_L: res.read_data = {4'h0, ctrl_r[3:0]};
          SEL_CTRL_M: res.read_data = {4'h0, ctrl_r[7:4]};
          SEL_CTRL_H: res.read_data = {4'h0, ctrl_r[11:8]};
          SEL_RESET:  res.read_data = RD_RESET_REG;
          default:    res.read_data = RD_UNMAPPED;
        endcase
      end
      OP_VSYNC: begin
        fill_ptr   = '0;
        lines_seen = 0;
        held_ok    = 1'b0;
        held_pix   = '0;
        panel_len  = int'(vlines_r) + 3;
        if (vstart_r > VSTART_TOP) begin
          skip_frame = 1'b1;
          skip_left  = 0;
        end else begin
          skip_frame = 1'b0;
          skip_left  = int'(VSTART_TOP) - int'(vstart_r);
        end
      end
      OP_PIXEL: begin
        if (line_live()) begin
          half = ctrl_r[6:5] == MODE_HALF;
          off  = int'(HSTART_MAX) - ((hstart_r > HSTART_MAX) ? int'(HSTART_MAX)
                                                               : int'(hstart_r));
          lim  = int'(hlen_r) * (half ? 4 : 8);
          if (half) begin
            off = off / 2;
          end
          cnt = (npix > MAX_LINE) ? MAX_LINE : int'(npix);
          if (lim < cnt) begin
            cnt = lim;
          end
          cnt = (cnt + 1) & ~32'd1;
          if (pos >= off && pos - off < cnt) begin
            rel = pos - off;
            if (half) begin
              append_byte({pix, pix});
            end else if (rel % 2 == 0) begin
              held_pix = pix;
              held_ok  = 1'b1;
            end else begin
              append_byte({pix, held_ok ? held_pix : 4'h0});
              held_ok = 1'b0;
            end
          end
        end
      end
      OP_EOL: begin
        if (!skip_frame) begin
          if (skip_left != 0) begin
            skip_left--;
            held_ok = 1'b0;
          end else begin
            if (held_ok && line_live()) begin
              append_byte({4'h0, held_pix});
            end
            held_ok  = 1'b0;
            held_pix = '0;
            if (lines_seen < LINE_COUNT_MAX) begin
              lines_seen++;
            end
            res.frame_ready = lines_seen == panel_len || lines_seen == 2 * panel_len;
          end
        end
      end
      OP_FRAME_RD: begin
        stored        = frame_image[faddr];
        res.grey_even = GREY_LEVELS[8*grey_idx[stored[3:0]] +: 8];
        res.grey_odd  = GREY_LEVELS[8*grey_idx[stored[7:4]] +: 8];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    lcd_result_t seen;
    lcd_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(capture_outcome(opcode_i, reg_addr_i, write_data_i,
                                                  pixel_pos_i, pixel_value_i,
                                                  line_pixels_i, frame_addr_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{read_data: read_data_i, grey_even: grey_even_i,
                 grey_odd: grey_odd_i, frame_ready: frame_ready_i};
        if (awaited_results.size() == 0) begin
          log_failure($sformatf("%0t: result with no request outstanding, actual %h",
                                $time, seen));
        end else begin
          want = awaited_results.pop_front();
          if (seen.read_data !== want.read_data) begin
            log_failure($sformatf("%0t: read_data expected %0d actual %0d",
                                  $time, want.read_data, seen.read_data));
          end
          if (seen.grey_even !== want.grey_even) begin
            log_failure($sformatf("%0t: grey_even expected %0d actual %0d",
                                  $time, want.grey_even, seen.grey_even));
          end
          if (seen.grey_odd !== want.grey_odd) begin
            log_failure($sformatf("%0t: grey_odd expected %0d actual %0d",
                                  $time, want.grey_odd, seen.grey_odd));
          end
          if (seen.frame_ready !== want.frame_ready) begin
            log_failure($sformatf("%0t: frame_ready expected %0d actual %0d",
                                  $time, want.frame_ready, seen.frame_ready));
          end
        end
      end
      due_count <= awaited_results.size();
    end
  end

endmodule

// ===== sim/lcd_line_capture_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD line capture controller testbench
// Drives register, vsync, pixel, end-of-line and frame read requests into the
// controller. A short directed opening is followed by randomised frames under
// four idle and stall phases. All checking is done in the checker module.
// ----------------------------------------------------------------------------
module lcd_line_capture_controller_tb;
  import lcc_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 10;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int PHASE_COUNT     = 4;

  localparam logic [6:0] ADDR_VSTART  = 7'h00;
  localparam logic [6:0] ADDR_VLINES  = 7'h0c;
  localparam logic [6:0] ADDR_HSTART  = 7'h18;
  localparam logic [6:0] ADDR_HLEN    = 7'h24;
  localparam logic [6:0] ADDR_CTRL    = 7'h30;
  localparam logic [6:0] ADDR_RESET   = 7'h3c;
  localparam logic [6:0] ADDR_PALETTE = 7'h40;
  localparam logic [6:0] ADDR_TOP     = 7'h7f;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode      = '0;
  logic [6:0]  reg_addr    = '0;
  logic [7:0]  write_data  = '0;
  logic [11:0] pixel_pos   = '0;
  logic [3:0]  pixel_value = '0;
  logic [12:0] line_pixels = '0;
  logic [17:0] frame_addr  = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  read_data;
  logic [7:0]  grey_even;
  logic [7:0]  grey_odd;
  logic        frame_ready;
  int          fail_count;
  int          results_due;

  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          requests_sent = 0;
  logic [11:0] cur_hstart  = '0;
  bit          cur_half    = 1'b0;

  lcd_line_capture_controller u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .reg_addr_i    (reg_addr),
    .write_data_i  (write_data),
    .pixel_pos_i   (pixel_pos),
    .pixel_value_i (pixel_value),
    .line_pixels_i (line_pixels),
    .frame_addr_i  (frame_addr),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data),
    .grey_even_o   (grey_even),
    .grey_odd_o    (grey_odd),
    .frame_ready_o (frame_ready)
  );

  lcc_capture_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .reg_addr_i    (reg_addr),
    .write_data_i  (write_data),
    .pixel_pos_i   (pixel_pos),
    .pixel_value_i (pixel_value),
    .line_pixels_i (line_pixels),
    .frame_addr_i  (frame_addr),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_i   (read_data),
    .grey_even_i   (grey_even),
    .grey_odd_i    (grey_odd),
    .frame_ready_i (frame_ready),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= $urandom_range(0, 99) >= stall_pct;
  end

  task automatic send_request(input logic [2:0] op, input logic [6:0] addr,
                              input logic [7:0] data, input logic [11:0] pos,
                              input logic [3:0] pix, input logic [12:0] npix,
                              input logic [17:0] faddr);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    reg_addr    <= addr;
    write_data  <= data;
    pixel_pos   <= pos;
    pixel_value <= pix;
    line_pixels <= npix;
    frame_addr  <= faddr;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    requests_sent++;
  endtask

  task automatic write_reg(input logic [6:0] addr, input logic [7:0] data);
    send_request(OP_REG_WR, addr, data, 12'($urandom), 4'($urandom), 13'($urandom),
                 18'($urandom));
  endtask

  task automatic read_reg(input logic [6:0] addr);
    send_request(OP_REG_RD, addr, 8'($urandom), 12'($urandom), 4'($urandom),
                 13'($urandom), 18'($urandom));
  endtask

  task automatic send_pixel(input logic [11:0] pos, input logic [3:0] pix,
                            input logic [12:0] npix);
    send_request(OP_PIXEL, 7'($urandom), 8'($urandom), pos, pix, npix, 18'($urandom));
  endtask

  task automatic read_frame(input logic [17:0] faddr);
    send_request(OP_FRAME_RD, 7'($urandom), 8'($urandom), 12'($urandom), 4'($urandom),
                 13'($urandom), faddr);
  endtask

  task automatic send_bare(input logic [2:0] op);
    send_request(op, 7'($urandom), 8'($urandom), 12'($urandom), 4'($urandom),
                 13'($urandom), 18'($urandom));
  endtask

  // Writes all three nibbles of a timing register, with noise in the unused bits.
  task automatic set_timing(input logic [6:0] base, input logic [11:0] value);
    for (int nib = 0; nib < 3; nib++) begin
      write_reg(base + 7'(4 * nib) + 7'($urandom_range(0, 3)),
                {4'($urandom), value[4*nib +: 4]});
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: read_frame(18'($urandom));
      1: read_reg(7'($urandom));
      2: send_bare($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI);
      3: send_pixel(12'($urandom), 4'($urandom), 13'($urandom));
      default: write_reg(ADDR_RESET + 7'($urandom_range(0, 3)), 8'($urandom));
    endcase
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) begin
      @(posedge clk);
    end
  endtask

  // One frame: optional new timing and palette, usually a vsync, then a few lines of
  // pixels in position order around the capture window and some readback.
  task automatic play_frame();
    int          pick;
    int          len;
    int          first;
    int          off;
    int          npix;
    logic [11:0] value;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      if (pick < 70) value = 12'(int'(VSTART_TOP) - $urandom_range(0, 4));
      else if (pick < 85) value = 12'($urandom_range(int'(VSTART_TOP) + 1, 4095));
      else value = 12'($urandom);
      set_timing(ADDR_VSTART, value);
    end
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) begin
      value = (pick < 85) ? 12'($urandom_range(0, 3)) : 12'($urandom);
      set_timing(ADDR_VLINES, value);
    end
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      if (pick < 60) value = 12'(int'(HSTART_MAX) - $urandom_range(0, 7));
      else if (pick < 80) value = 12'($urandom_range(int'(HSTART_MAX) + 1, 4095));
      else value = 12'($urandom);
      set_timing(ADDR_HSTART, value);
      cur_hstart = value;
    end
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      if (pick < 70) value = 12'($urandom_range(1, 3));
      else if (pick < 85) value = '0;
      else value = 12'($urandom);
      set_timing(ADDR_HLEN, value);
    end
    if ($urandom_range(0, 2) == 0) begin
      value = 12'($urandom);
      if ($urandom_range(0, 99) < 45) value[6:5] = MODE_HALF;
      set_timing(ADDR_CTRL, value);
      cur_half = value[6:5] == MODE_HALF;
    end
    repeat ($urandom_range(0, 3)) begin
      write_reg(ADDR_PALETTE + 7'($urandom_range(0, 63)), 8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) read_reg(ADDR_CTRL + 7'($urandom_range(0, 15)));
    if ($urandom_range(0, 19) != 0) send_bare(OP_VSYNC);
    off = int'(HSTART_MAX) - ((cur_hstart > HSTART_MAX) ? int'(HSTART_MAX)
                                                         : int'(cur_hstart));
    if (cur_half) off = off / 2;
    repeat ($urandom_range(0, 10)) begin
      len   = $urandom_range(0, 24);
      first = off - $urandom_range(0, 2);
      if (first < 0) first = 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) npix = len;
      else if (pick < 85) npix = $urandom_range(0, len + 4);
      else if (pick < 95) npix = $urandom_range(MAX_LINE, 8191);
      else npix = $urandom_range(0, 8191);
      for (int k = 0; k < len && first + k < MAX_LINE; k++) begin
        if ($urandom_range(0, 99) < 4) send_noise();
        if ($urandom_range(0, 99) >= 8) begin
          send_pixel(12'(first + k), 4'($urandom), 13'(npix));
        end
      end
      if ($urandom_range(0, 19) != 0) send_bare(OP_EOL);
    end
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 3) != 0) read_frame(18'($urandom_range(0, 15)));
      else read_frame(18'($urandom));
    end
  endtask

  initial begin
    int phase_end;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    read_frame('0);
    read_frame('1);
    read_reg(ADDR_RESET);
    read_reg(ADDR_TOP);
    send_bare(OP_SPARE_LO);
    send_bare(OP_SPARE_HI);
    write_reg(ADDR_VSTART + 7'd8, 8'hf2);
    write_reg(ADDR_VSTART, 8'h01);
    send_bare(OP_VSYNC);
    send_pixel(12'd0, 4'hf, 13'd8);
    send_bare(OP_EOL);
    write_reg(ADDR_VSTART, 8'h00);
    write_reg(ADDR_HSTART + 7'd8, 8'h0f);
    write_reg(ADDR_HLEN, 8'h01);
    write_reg(ADDR_PALETTE + 7'(4 * 15), 8'h08);
    send_bare(OP_VSYNC);
    send_pixel(12'd0, 4'hf, 13'd3);
    send_pixel(12'd1, 4'h0, 13'd3);
    send_pixel(12'd2, 4'hf, 13'h1fff);
    send_bare(OP_EOL);
    read_frame(18'd0);
    read_frame(18'd1);
    read_reg(ADDR_CTRL);
    cur_hstart = 12'hf00;
    cur_half   = 1'b0;

    phase_end = requests_sent;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 72; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 72; end
        default: begin idle_pct = 13; stall_pct <= 13; end
      endcase
      phase_end += RANDOM_REQUESTS / PHASE_COUNT;
      while (requests_sent < phase_end) begin
        play_frame();
      end
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
